@@ sv/fgat_pkg.sv @@
// Shared widths, codes and register defaults for the group allocation table.
// Used by fgat_div and fat_group_allocation_table.
package fgat_pkg;

   localparam int GROUP_W    = 10;
   localparam int CODE_W     = 12;
   localparam int GPT_W      = 7;
   localparam int BPG_W      = 16;
   localparam int COUNT_W    = 11;
   localparam int BYTES_W    = 26;
   localparam int OP_W       = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;
   // track bases and scan positions, wide enough to compare against the table depth
   localparam int NUM_W      = 13;

   localparam int MAX_GROUPS_DEF = 1024;
   localparam int ENTRY_BITS_DEF = 12;

   localparam logic [GROUP_W-1:0] LAST_GROUP_RST       = 10'd1023;
   localparam logic [CODE_W-1:0]  UNUSED_CODE_RST      = 12'd255;
   localparam logic [CODE_W-1:0]  SYSTEM_CODE_RST      = 12'd254;
   localparam logic [CODE_W-1:0]  FINAL_CODE_RST       = 12'd192;
   localparam logic [GPT_W-1:0]   GROUPS_PER_TRACK_RST = 7'd8;
   localparam logic [GROUP_W-1:0] MANAGED_START_RST    = 10'd0;
   localparam logic [BPG_W-1:0]   BYTES_PER_GROUP_RST  = 16'd4096;

   typedef enum logic [OP_W-1:0] {
      OP_WRITE      = 3'd0,
      OP_READ       = 3'd1,
      OP_FIRST_FREE = 3'd2,
      OP_NEAR_FREE  = 3'd3,
      OP_COUNT      = 3'd4
   } op_type;

   typedef enum logic [2:0] {
      REG_LAST_GROUP       = 3'd0,
      REG_UNUSED_CODE      = 3'd1,
      REG_SYSTEM_CODE      = 3'd2,
      REG_FINAL_CODE       = 3'd3,
      REG_GROUPS_PER_TRACK = 3'd4,
      REG_MANAGED_START    = 3'd5,
      REG_BYTES_PER_GROUP  = 3'd6
   } csr_index_type;

endpackage

@@ sv/fgat_ram.sv @@
// Single-port table memory with registered read data.
// Generic; no package dependencies.
module fgat_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 12
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wdata;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/fgat_div.sv @@
// Bit-serial remainder unit: one dividend bit per cycle, done pulses after GROUP_W steps.
// Depends on fgat_pkg for widths.
module fgat_div (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [fgat_pkg::GROUP_W-1:0] dividend,
   input  logic [fgat_pkg::GPT_W-1:0]   divisor,
   output logic                       done,
   output logic [fgat_pkg::GPT_W-1:0]   remainder
);
   import fgat_pkg::*;

   localparam int STEP_W = $clog2(GROUP_W + 1);

   logic               busy_ff;
   logic               done_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [GROUP_W-1:0] shift_ff;
   logic [GPT_W-1:0]   rem_ff;
   logic [GPT_W-1:0]   rem_in;
   logic [GPT_W-1:0]   divisor_ff;
   logic [GPT_W:0]     trial;

   // restoring step: partial remainder stays below the divisor
   always_comb begin
      trial  = {rem_ff, shift_ff[GROUP_W-1]};
      rem_in = (trial >= {1'b0, divisor_ff}) ? GPT_W'(trial - {1'b0, divisor_ff})
                                             : GPT_W'(trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff    <= 1'b1;
            step_ff    <= STEP_W'(GROUP_W);
            shift_ff   <= dividend;
            rem_ff     <= '0;
            divisor_ff <= divisor;
         end else if (busy_ff) begin
            shift_ff <= {shift_ff[GROUP_W-2:0], 1'b0};
            rem_ff   <= rem_in;
            step_ff  <= step_ff - STEP_W'(1);
            if (step_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

`ifndef SYNTH
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("remainder unit restarted while busy");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < divisor_ff))
      else $error("remainder not below divisor");

   a_done_ends_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> ($past(busy_ff) && !busy_ff))
      else $error("done without a finished run");
`endif

endmodule

@@ sv/fat_group_allocation_table.sv @@
// Group allocation table: a write answers in the next cycle and busy stays low; a read answers
// from S_READ after the registered table read. First free and count walk the groups up to the
// scan limit, one table read a cycle through the single memory port while within the limit.
// Near search: two 10-step remainder runs, then a two-pass walk of the table from the start track.
// One item at a time while busy. Synchronous reset: registers to defaults, table undefined.
module fat_group_allocation_table #(
   parameter int MAX_GROUPS = fgat_pkg::MAX_GROUPS_DEF,
   parameter int ENTRY_BITS = fgat_pkg::ENTRY_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [fgat_pkg::OP_W-1:0]        req_op,
   input  logic [fgat_pkg::GROUP_W-1:0]     req_group_index,
   input  logic [fgat_pkg::CODE_W-1:0]      req_entry_value,
   output logic                             rsp_valid,
   output logic                             rsp_found,
   output logic [fgat_pkg::GROUP_W-1:0]     rsp_found_group,
   output logic [fgat_pkg::CODE_W-1:0]      rsp_read_value,
   output logic [fgat_pkg::COUNT_W-1:0]     rsp_free_count,
   output logic [fgat_pkg::COUNT_W-1:0]     rsp_system_count,
   output logic [fgat_pkg::COUNT_W-1:0]     rsp_last_count,
   output logic [fgat_pkg::BYTES_W-1:0]     rsp_free_bytes,
   input  logic                             psel,
   input  logic                             penable,
   input  logic                             pwrite,
   input  logic [fgat_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [fgat_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [fgat_pkg::CSR_DATA_W-1:0]  prdata,
   output logic                             pready
);
   import fgat_pkg::*;

   localparam int ADDR_W = $clog2(MAX_GROUPS);
   localparam int CMP_W  = (ENTRY_BITS > CODE_W) ? ENTRY_BITS : CODE_W;
   localparam int CNT_W  = $clog2(MAX_GROUPS + 1);
   localparam int PROD_W = CNT_W + BPG_W;

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_DIV_FROM, S_DIV_MAN, S_SCAN, S_COUNT, S_PRODUCT
   } state_type;

   // ---------------- configuration registers ----------------
   logic [GROUP_W-1:0] cfg_last_group_ff;
   logic [CODE_W-1:0]  cfg_unused_code_ff;
   logic [CODE_W-1:0]  cfg_system_code_ff;
   logic [CODE_W-1:0]  cfg_final_code_ff;
   logic [GPT_W-1:0]   cfg_gpt_ff;
   logic [GROUP_W-1:0] cfg_managed_start_ff;
   logic [BPG_W-1:0]   cfg_bpg_ff;
   logic               csr_write;

   assign csr_write = psel && penable && pwrite;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_last_group_ff    <= LAST_GROUP_RST;
         cfg_unused_code_ff   <= UNUSED_CODE_RST;
         cfg_system_code_ff   <= SYSTEM_CODE_RST;
         cfg_final_code_ff    <= FINAL_CODE_RST;
         cfg_gpt_ff           <= GROUPS_PER_TRACK_RST;
         cfg_managed_start_ff <= MANAGED_START_RST;
         cfg_bpg_ff           <= BYTES_PER_GROUP_RST;
      end else if (csr_write) begin
         unique case (paddr[4:2])
            REG_LAST_GROUP:       cfg_last_group_ff    <= pwdata[GROUP_W-1:0];
            REG_UNUSED_CODE:      cfg_unused_code_ff   <= pwdata[CODE_W-1:0];
            REG_SYSTEM_CODE:      cfg_system_code_ff   <= pwdata[CODE_W-1:0];
            REG_FINAL_CODE:       cfg_final_code_ff    <= pwdata[CODE_W-1:0];
            REG_GROUPS_PER_TRACK: cfg_gpt_ff           <= pwdata[GPT_W-1:0];
            REG_MANAGED_START:    cfg_managed_start_ff <= pwdata[GROUP_W-1:0];
            REG_BYTES_PER_GROUP:  cfg_bpg_ff           <= pwdata[BPG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (paddr[4:2])
         REG_LAST_GROUP:       prdata = CSR_DATA_W'(cfg_last_group_ff);
         REG_UNUSED_CODE:      prdata = CSR_DATA_W'(cfg_unused_code_ff);
         REG_SYSTEM_CODE:      prdata = CSR_DATA_W'(cfg_system_code_ff);
         REG_FINAL_CODE:       prdata = CSR_DATA_W'(cfg_final_code_ff);
         REG_GROUPS_PER_TRACK: prdata = CSR_DATA_W'(cfg_gpt_ff);
         REG_MANAGED_START:    prdata = CSR_DATA_W'(cfg_managed_start_ff);
         REG_BYTES_PER_GROUP:  prdata = CSR_DATA_W'(cfg_bpg_ff);
         default:              prdata = '0;
      endcase
   end

   // ---------------- sequencer state ----------------
   state_type          state_ff, state_in;
   logic [GROUP_W-1:0] gi_ff, gi_in;
   logic [NUM_W-1:0]   base_ff, base_in;
   logic [GPT_W-1:0]   slot_ff, slot_in;
   logic               dir_up_ff, dir_up_in;
   logic               pass_ff, pass_in;
   logic               gen_done_ff, gen_done_in;
   logic               pend_vld_ff, pend_vld_in;
   logic [ADDR_W-1:0]  pend_addr_ff, pend_addr_in;
   logic [NUM_W-1:0]   man_base_ff, man_base_in;
   logic [CNT_W-1:0]   nf_ff, nf_in;
   logic [CNT_W-1:0]   ns_ff, ns_in;
   logic [CNT_W-1:0]   nl_ff, nl_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_found_ff, rsp_found_in;
   logic [GROUP_W-1:0] rsp_found_group_ff, rsp_found_group_in;
   logic [CODE_W-1:0]  rsp_read_value_ff, rsp_read_value_in;
   logic [COUNT_W-1:0] rsp_free_count_ff, rsp_free_count_in;
   logic [COUNT_W-1:0] rsp_system_count_ff, rsp_system_count_in;
   logic [COUNT_W-1:0] rsp_last_count_ff, rsp_last_count_in;
   logic [BYTES_W-1:0] rsp_free_bytes_ff, rsp_free_bytes_in;

   // ---------------- datapath helpers ----------------
   logic                  accept;
   logic                  gi_ok;
   logic [GPT_W-1:0]      sed;
   logic [NUM_W-1:0]      lim;
   logic [NUM_W-1:0]      num;
   logic                  in_range;
   logic                  last_slot;
   logic                  gen_issue;
   logic [NUM_W-1:0]      gen_base_nx;
   logic [GPT_W-1:0]      gen_slot_nx;
   logic                  gen_dir_nx;
   logic                  gen_pass_nx;
   logic                  gen_done_nx;
   logic                  pass_end;
   logic [CMP_W-1:0]      entry;
   logic                  is_free;
   logic                  is_system;
   logic                  is_final;
   logic [PROD_W-1:0]     product;

   logic                  ram_wr_en;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_addr;
   logic [ENTRY_BITS-1:0] ram_wdata;
   logic [ENTRY_BITS-1:0] ram_rd_data;

   logic                  div_start;
   logic [GROUP_W-1:0]    div_dividend;
   logic                  div_done;
   logic [GPT_W-1:0]      div_rem;

   assign accept    = start && (state_ff == S_IDLE);
   assign gi_ok     = NUM_W'(req_group_index) < NUM_W'(MAX_GROUPS);
   assign sed       = (cfg_gpt_ff == '0) ? GPT_W'(1) : cfg_gpt_ff;
   assign lim       = (NUM_W'(cfg_last_group_ff) > NUM_W'(MAX_GROUPS - 1))
                      ? NUM_W'(MAX_GROUPS - 1) : NUM_W'(cfg_last_group_ff);
   assign num       = base_ff + NUM_W'(slot_ff);
   assign in_range  = num <= lim;
   assign last_slot = slot_ff == (sed - GPT_W'(1));
   assign gen_issue = ((state_ff == S_SCAN) || (state_ff == S_COUNT)) && !gen_done_ff
                      && in_range;

   assign entry     = CMP_W'(ram_rd_data);
   assign is_free   = entry == CMP_W'(cfg_unused_code_ff);
   assign is_system = entry == CMP_W'(cfg_system_code_ff);
   assign is_final  = entry >= CMP_W'(cfg_final_code_ff);
   assign product   = PROD_W'(nf_ff) * PROD_W'(cfg_bpg_ff);

   // walk order: groups of a track in turn, tracks up or down, then the second pass
   always_comb begin
      gen_base_nx = base_ff;
      gen_slot_nx = slot_ff + GPT_W'(1);
      gen_dir_nx  = dir_up_ff;
      gen_pass_nx = pass_ff;
      gen_done_nx = gen_done_ff;
      pass_end    = 1'b0;
      if (dir_up_ff && (slot_ff == '0) && !in_range) begin
         pass_end = 1'b1;
      end else if (!in_range || last_slot) begin
         gen_slot_nx = '0;
         if (dir_up_ff) begin
            gen_base_nx = base_ff + NUM_W'(sed);
         end else if (base_ff == '0) begin
            pass_end = 1'b1;
         end else begin
            gen_base_nx = base_ff - NUM_W'(sed);
         end
      end
      if (pass_end) begin
         gen_slot_nx = '0;
         if (!pass_ff) begin
            gen_pass_nx = 1'b1;
            gen_dir_nx  = !dir_up_ff;
            gen_base_nx = man_base_ff;
         end else begin
            gen_done_nx = 1'b1;
         end
      end
   end

   assign ram_wr_en    = accept && (req_op == OP_WRITE) && gi_ok;
   assign ram_rd_en    = (accept && (req_op == OP_READ) && gi_ok) || gen_issue;
   assign ram_addr     = (state_ff == S_IDLE) ? ADDR_W'(req_group_index) : num[ADDR_W-1:0];
   assign ram_wdata    = ENTRY_BITS'(req_entry_value);

   assign div_start    = (accept && (req_op == OP_NEAR_FREE))
                         || ((state_ff == S_DIV_FROM) && div_done);
   assign div_dividend = (state_ff == S_IDLE) ? req_group_index : cfg_managed_start_ff;

   always_comb begin
      state_in            = state_ff;
      gi_in               = gi_ff;
      base_in             = base_ff;
      slot_in             = slot_ff;
      dir_up_in           = dir_up_ff;
      pass_in             = pass_ff;
      gen_done_in         = gen_done_ff;
      pend_vld_in         = gen_issue;
      pend_addr_in        = num[ADDR_W-1:0];
      man_base_in         = man_base_ff;
      nf_in               = nf_ff;
      ns_in               = ns_ff;
      nl_in               = nl_ff;
      rsp_valid_in        = 1'b0;
      rsp_found_in        = 1'b0;
      rsp_found_group_in  = '0;
      rsp_read_value_in   = '0;
      rsp_free_count_in   = '0;
      rsp_system_count_in = '0;
      rsp_last_count_in   = '0;
      rsp_free_bytes_in   = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               base_in     = '0;
               slot_in     = '0;
               dir_up_in   = 1'b1;
               pass_in     = 1'b1;
               gen_done_in = 1'b0;
               nf_in       = '0;
               ns_in       = '0;
               nl_in       = '0;
               gi_in       = req_group_index;
               case (req_op)
                  OP_WRITE: rsp_valid_in = 1'b1;
                  OP_READ: begin
                     if (gi_ok) begin
                        state_in = S_READ;
                     end else begin
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_FIRST_FREE: state_in = S_SCAN;
                  OP_NEAR_FREE:  state_in = S_DIV_FROM;
                  OP_COUNT:      state_in = S_COUNT;
                  default:       rsp_valid_in = 1'b1;
               endcase
            end
         end
         S_READ: begin
            rsp_valid_in      = 1'b1;
            rsp_read_value_in = CODE_W'(ram_rd_data);
            state_in          = S_IDLE;
         end
         S_DIV_FROM: begin
            if (div_done) begin
               // start track base = group - group mod T
               base_in  = NUM_W'(gi_ff) - NUM_W'(div_rem);
               state_in = S_DIV_MAN;
            end
         end
         S_DIV_MAN: begin
            if (div_done) begin
               man_base_in = NUM_W'(cfg_managed_start_ff) - NUM_W'(div_rem);
               dir_up_in   = base_ff >= man_base_in;
               slot_in     = '0;
               pass_in     = 1'b0;
               gen_done_in = 1'b0;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (pend_vld_ff && is_free) begin
               rsp_valid_in       = 1'b1;
               rsp_found_in       = 1'b1;
               rsp_found_group_in = GROUP_W'(pend_addr_ff);
               pend_vld_in        = 1'b0;
               state_in           = S_IDLE;
            end else if (gen_done_ff && !pend_vld_ff) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (!gen_done_ff) begin
               base_in     = gen_base_nx;
               slot_in     = gen_slot_nx;
               dir_up_in   = gen_dir_nx;
               pass_in     = gen_pass_nx;
               gen_done_in = gen_done_nx;
            end
         end
         S_COUNT: begin
            if (pend_vld_ff) begin
               priority if (is_free) begin
                  nf_in = nf_ff + CNT_W'(1);
               end else if (is_system) begin
                  ns_in = ns_ff + CNT_W'(1);
               end else if (is_final) begin
                  nl_in = nl_ff + CNT_W'(1);
               end else begin
                  nf_in = nf_ff;
               end
            end
            if (gen_done_ff && !pend_vld_ff) begin
               state_in = S_PRODUCT;
            end else if (!gen_done_ff) begin
               base_in     = gen_base_nx;
               slot_in     = gen_slot_nx;
               dir_up_in   = gen_dir_nx;
               pass_in     = gen_pass_nx;
               gen_done_in = gen_done_nx;
            end
         end
         S_PRODUCT: begin
            rsp_valid_in        = 1'b1;
            rsp_free_count_in   = COUNT_W'(nf_ff);
            rsp_system_count_in = COUNT_W'(ns_ff);
            rsp_last_count_in   = COUNT_W'(nl_ff);
            rsp_free_bytes_in   = BYTES_W'(product);
            state_in            = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         gen_done_ff  <= 1'b0;
         pend_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gen_done_ff  <= gen_done_in;
         pend_vld_ff  <= pend_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      gi_ff               <= gi_in;
      base_ff             <= base_in;
      slot_ff             <= slot_in;
      dir_up_ff           <= dir_up_in;
      pass_ff             <= pass_in;
      pend_addr_ff        <= pend_addr_in;
      man_base_ff         <= man_base_in;
      nf_ff               <= nf_in;
      ns_ff               <= ns_in;
      nl_ff               <= nl_in;
      rsp_found_ff        <= rsp_found_in;
      rsp_found_group_ff  <= rsp_found_group_in;
      rsp_read_value_ff   <= rsp_read_value_in;
      rsp_free_count_ff   <= rsp_free_count_in;
      rsp_system_count_ff <= rsp_system_count_in;
      rsp_last_count_ff   <= rsp_last_count_in;
      rsp_free_bytes_ff   <= rsp_free_bytes_in;
   end

   assign busy             = state_ff != S_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_found_group  = rsp_found_group_ff;
   assign rsp_read_value   = rsp_read_value_ff;
   assign rsp_free_count   = rsp_free_count_ff;
   assign rsp_system_count = rsp_system_count_ff;
   assign rsp_last_count   = rsp_last_count_ff;
   assign rsp_free_bytes   = rsp_free_bytes_ff;

   fgat_ram #(
      .DEPTH (MAX_GROUPS),
      .WIDTH (ENTRY_BITS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .rd_en   (ram_rd_en),
      .addr    (ram_addr),
      .wdata   (ram_wdata),
      .rd_data (ram_rd_data)
   );

   fgat_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .divisor   (sed),
      .done      (div_done),
      .remainder (div_rem)
   );

`ifndef SYNTH
   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_found_ff) |-> (NUM_W'(rsp_found_group_ff) <= lim))
      else $error("found group beyond scan limit");

   a_pending_in_walk: assert property (@(posedge clock) disable iff (reset)
      pend_vld_ff |-> ((state_ff == S_SCAN) || (state_ff == S_COUNT)))
      else $error("pending table read outside a walk");

   a_result_on_return: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_IDLE) && ($past(state_ff) != S_IDLE) && !$past(reset))
      |-> rsp_valid_ff)
      else $error("busy period ended without a result");
`endif

endmodule
